### src/psstore_pkg.sv
// Shared constants, action codes and payload types for the positional sequence store.
package psstore_pkg;

    localparam int unsigned DEPTH  = 64;
    localparam int unsigned ADDR_W = $clog2(DEPTH);
    localparam int unsigned CNT_W  = $clog2(DEPTH + 1);
    localparam int unsigned POS_W  = 7;
    localparam int unsigned WORD_W = 32;
    localparam int unsigned ACT_W  = 3;

    localparam logic [ACT_W-1:0] ACT_GET    = 3'd0;
    localparam logic [ACT_W-1:0] ACT_FIND   = 3'd1;
    localparam logic [ACT_W-1:0] ACT_INSERT = 3'd2;
    localparam logic [ACT_W-1:0] ACT_DELETE = 3'd3;
    localparam logic [ACT_W-1:0] ACT_SET    = 3'd4;
    localparam logic [ACT_W-1:0] ACT_CLEAR  = 3'd5;

    typedef struct packed {
        logic [ACT_W-1:0]         action;
        logic [POS_W-1:0]         position;
        logic signed [WORD_W-1:0] value;
    } in_t;

    typedef struct packed {
        logic                     ok;
        logic signed [WORD_W-1:0] data;
        logic [POS_W-1:0]         found_position;
        logic [POS_W-1:0]         count;
        logic                     empty_res;
    } out_t;

    typedef struct packed {
        logic              we;
        logic [ADDR_W-1:0] waddr;
        logic [WORD_W-1:0] wdata;
        logic [ADDR_W-1:0] raddr;
    } ram_req_t;

endpackage

### src/positional_sequence_store_unit.sv
// From accept: clear and rejected words go straight to the result, set writes the entry,
// get reads it through the registered read port, find compares entries in order until a
// hit or the list end, insert shifts entries up then writes the value, delete shifts down.
// One word at a time, the next taken in the cycle after the result moves out;
// one memory port moves or compares one entry per cycle. Reset: fill, control clear.
// Top level: sequencer, entry memory and output register.
module positional_sequence_store_unit (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  psstore_pkg::in_t  in_data,
    output logic              out_valid,
    input  logic              out_ready,
    output psstore_pkg::out_t out_data
);
    import psstore_pkg::*;

    ram_req_t          ram_req;
    logic [WORD_W-1:0] ram_rdata;
    logic              res_valid;
    logic              res_ready;
    out_t              res_data;
    logic              out_valid_reg;
    out_t              out_reg;

    psstore_ram u_ram (
        .clk   (clk),
        .req   (ram_req),
        .rdata (ram_rdata)
    );

    psstore_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res_data  (res_data),
        .ram_req   (ram_req),
        .ram_rdata (ram_rdata)
    );

    assign res_ready = !out_valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (res_valid && res_ready)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_valid && res_ready)
        begin
            out_reg <= res_data;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

endmodule

### src/psstore_ram.sv
// Entry storage: one write port, one registered read port.
module psstore_ram (
    input  logic                               clk,
    input  psstore_pkg::ram_req_t              req,
    output logic [psstore_pkg::WORD_W-1:0]     rdata
);
    import psstore_pkg::*;

    logic [WORD_W-1:0] mem [DEPTH];
    logic [WORD_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (req.we)
        begin
            mem[req.waddr] <= req.wdata;
        end
        rdata_reg <= mem[req.raddr];
    end

    assign rdata = rdata_reg;

endmodule

### src/psstore_ctrl.sv
// Sequencer: range checks, entry shifting, linear search and result assembly.
module psstore_ctrl (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    output logic                               in_ready,
    input  psstore_pkg::in_t                   in_data,
    output logic                               res_valid,
    input  logic                               res_ready,
    output psstore_pkg::out_t                  res_data,
    output psstore_pkg::ram_req_t              ram_req,
    input  logic [psstore_pkg::WORD_W-1:0]     ram_rdata
);
    import psstore_pkg::*;

    localparam int unsigned EW = ((CNT_W > POS_W) ? CNT_W : POS_W) + 1;

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_GET   = 3'd1;
    localparam logic [2:0] ST_GETW  = 3'd2;
    localparam logic [2:0] ST_FIND  = 3'd3;
    localparam logic [2:0] ST_SHIFT = 3'd4;
    localparam logic [2:0] ST_PUT   = 3'd5;
    localparam logic [2:0] ST_DONE  = 3'd6;

    logic [2:0]        state_reg, state_next;
    logic [CNT_W-1:0]  fill_reg, fill_next;
    logic              pend_valid_reg, pend_valid_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic [ADDR_W-1:0] rd_idx_reg, rd_idx_next;
    logic [ADDR_W-1:0] pend_addr_reg, pend_addr_next;
    logic [ADDR_W-1:0] put_addr_reg, put_addr_next;
    logic              up_reg, up_next;
    logic [WORD_W-1:0] value_reg, value_next;
    logic              ok_reg, ok_next;
    logic [WORD_W-1:0] data_reg, data_next;
    logic [POS_W-1:0]  where_reg, where_next;

    logic [EW-1:0] pos_e;
    logic [EW-1:0] fill_e;
    logic          pos_nz;
    logic          in_rng;
    logic          ins_rng;
    logic          match;

    assign pos_e   = EW'(in_data.position);
    assign fill_e  = EW'(fill_reg);
    assign pos_nz  = (pos_e != '0);
    assign in_rng  = pos_nz && (pos_e <= fill_e);
    assign ins_rng = pos_nz && (pos_e <= fill_e + EW'(1)) && (fill_e < EW'(DEPTH));
    assign match   = (ram_rdata == value_reg);

    assign in_ready  = (state_reg == ST_IDLE);
    assign res_valid = (state_reg == ST_DONE);

    always_comb
    begin
        res_data.ok             = ok_reg;
        res_data.data           = data_reg;
        res_data.found_position = where_reg;
        res_data.count          = POS_W'(fill_reg);
        res_data.empty_res      = (fill_reg == '0);
    end

    always_comb
    begin
        state_next      = state_reg;
        fill_next       = fill_reg;
        pend_valid_next = pend_valid_reg;
        cnt_next        = cnt_reg;
        rd_idx_next     = rd_idx_reg;
        pend_addr_next  = pend_addr_reg;
        put_addr_next   = put_addr_reg;
        up_next         = up_reg;
        value_next      = value_reg;
        ok_next         = ok_reg;
        data_next       = data_reg;
        where_next      = where_reg;

        ram_req.we    = 1'b0;
        ram_req.waddr = pend_addr_reg;
        ram_req.wdata = ram_rdata;
        ram_req.raddr = rd_idx_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    ok_next         = 1'b0;
                    data_next       = '0;
                    where_next      = '0;
                    pend_valid_next = 1'b0;
                    value_next      = in_data.value;
                    put_addr_next   = ADDR_W'(pos_e - EW'(1));
                    state_next      = ST_DONE;
                    case (in_data.action)
                        ACT_GET:
                        begin
                            if (in_rng)
                            begin
                                state_next = ST_GET;
                            end
                        end
                        ACT_FIND:
                        begin
                            cnt_next    = fill_reg;
                            rd_idx_next = '0;
                            state_next  = ST_FIND;
                        end
                        ACT_INSERT:
                        begin
                            if (ins_rng)
                            begin
                                // move entries [pos-1 .. fill-1] up by one, top first
                                fill_next   = fill_reg + CNT_W'(1);
                                cnt_next    = CNT_W'(fill_e + EW'(1) - pos_e);
                                rd_idx_next = ADDR_W'(fill_e - EW'(1));
                                up_next     = 1'b1;
                                ok_next     = 1'b1;
                                state_next  = ST_SHIFT;
                            end
                        end
                        ACT_DELETE:
                        begin
                            if (in_rng)
                            begin
                                // move entries [pos .. fill-1] down by one, bottom first
                                fill_next   = fill_reg - CNT_W'(1);
                                cnt_next    = CNT_W'(fill_e - pos_e);
                                rd_idx_next = ADDR_W'(pos_e);
                                up_next     = 1'b0;
                                ok_next     = 1'b1;
                                state_next  = ST_SHIFT;
                            end
                        end
                        ACT_SET:
                        begin
                            if (in_rng)
                            begin
                                ok_next    = 1'b1;
                                state_next = ST_PUT;
                            end
                        end
                        ACT_CLEAR:
                        begin
                            fill_next = '0;
                            ok_next   = 1'b1;
                        end
                        default:
                        begin
                            state_next = ST_DONE;
                        end
                    endcase
                end
            end
            ST_GET:
            begin
                ram_req.raddr = put_addr_reg;
                state_next    = ST_GETW;
            end
            ST_GETW:
            begin
                data_next  = ram_rdata;
                ok_next    = 1'b1;
                state_next = ST_DONE;
            end
            ST_FIND:
            begin
                // read one entry a cycle, compare the previous read
                if (pend_valid_reg && match)
                begin
                    ok_next    = 1'b1;
                    where_next = POS_W'(CNT_W'(pend_addr_reg) + CNT_W'(1));
                    state_next = ST_DONE;
                end
                else if (cnt_reg != '0)
                begin
                    pend_valid_next = 1'b1;
                    pend_addr_next  = rd_idx_reg;
                    rd_idx_next     = rd_idx_reg + ADDR_W'(1);
                    cnt_next        = cnt_reg - CNT_W'(1);
                end
                else if (!pend_valid_reg)
                begin
                    state_next = ST_DONE;
                end
                else
                begin
                    pend_valid_next = 1'b0;
                end
            end
            ST_SHIFT:
            begin
                // write last cycle's read to its new slot while reading the next one
                ram_req.we = pend_valid_reg;
                if (cnt_reg != '0)
                begin
                    pend_valid_next = 1'b1;
                    pend_addr_next  = up_reg ? rd_idx_reg + ADDR_W'(1)
                                             : rd_idx_reg - ADDR_W'(1);
                    rd_idx_next     = up_reg ? rd_idx_reg - ADDR_W'(1)
                                             : rd_idx_reg + ADDR_W'(1);
                    cnt_next        = cnt_reg - CNT_W'(1);
                end
                else
                begin
                    pend_valid_next = 1'b0;
                    if (!pend_valid_reg)
                    begin
                        state_next = up_reg ? ST_PUT : ST_DONE;
                    end
                end
            end
            ST_PUT:
            begin
                ram_req.we    = 1'b1;
                ram_req.waddr = put_addr_reg;
                ram_req.wdata = value_reg;
                state_next    = ST_DONE;
            end
            ST_DONE:
            begin
                if (res_ready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            fill_reg       <= '0;
            pend_valid_reg <= 1'b0;
            cnt_reg        <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            fill_reg       <= fill_next;
            pend_valid_reg <= pend_valid_next;
            cnt_reg        <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_idx_reg    <= rd_idx_next;
        pend_addr_reg <= pend_addr_next;
        put_addr_reg  <= put_addr_next;
        up_reg        <= up_next;
        value_reg     <= value_next;
        ok_reg        <= ok_next;
        data_reg      <= data_next;
        where_reg     <= where_next;
    end

    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= CNT_W'(DEPTH))
        else $error("fill exceeds depth");

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("ready held after accepting a word");

    a_shift_no_collide: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SHIFT) && ram_req.we && (cnt_reg != '0)
            |-> ram_req.waddr != ram_req.raddr)
        else $error("shift writes the entry it reads");

    a_idle_no_write: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE) |-> !ram_req.we)
        else $error("memory written while idle");

endmodule
